// ===== design/fnbd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the four-neighbor boundary detector
// no dependencies; compiled first

package fnbd_pkg;

	// line memory depth default, handed to the top level parameter
	localparam int MAX_WIDTH_DEF = 1024;

	// field widths fixed by the register map and the result word
	localparam int IMG_W_BITS  = 11;
	localparam int ROW_W       = 16;
	localparam int OUT_COL_W   = 10;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	// register reset values
	localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = IMG_W_BITS'(1024);
	localparam logic [ROW_W-1:0]      HEIGHT_RESET = ROW_W'(1024);

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

	// result queue sizing (depth is a power of two)
	localparam int RES_PER_PIXEL = 3;
	localparam int RES_DEPTH     = 4;

	typedef struct packed {
		logic pixel_in;
	} pix_t;

	typedef struct packed {
		logic                   boundary;
		logic [ROW_W-1:0]       out_row;
		logic [OUT_COL_W-1:0]   out_col;
		logic                   frame_end;
	} result_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
	} cfg_t;

	// results made by one pixel, oldest in slot 0
	typedef struct packed {
		logic [RES_PER_PIXEL-1:0]    valid;
		result_t [RES_PER_PIXEL-1:0] item;
	} push_t;

endpackage

// ===== design/fnbd_stream_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying one word of any packed type
// payload types come from fnbd_pkg at the instance

interface fnbd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fnbd_res_queue.sv =====
`timescale 1ns / 1ps
// result queue: takes up to three results per cycle in order, drains one word a cycle while the reader is ready
// depends on fnbd_pkg and fnbd_stream_if

module fnbd_res_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  fnbd_pkg::push_t push,
	output logic            space_ok,
	fnbd_stream_if.source   res
);

	localparam int PW = $clog2(fnbd_pkg::RES_DEPTH);
	localparam int NP = fnbd_pkg::RES_PER_PIXEL;

	fnbd_pkg::result_t slot_q [fnbd_pkg::RES_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic [PW:0]   n_push;
	logic [PW-1:0] wr_idx [NP];
	logic          pop;

	// compact valid results onto consecutive free slots
	always_comb begin
		logic [PW:0] ofs;
		ofs = '0;
		for (int k = 0; k < NP; k++) begin
			wr_idx[k] = wr_ptr_q + ofs[PW-1:0];
			ofs = ofs + (PW+1)'(push.valid[k]);
		end
		n_push = ofs;
	end

	assign pop       = res.valid & res.ready;
	assign res.valid = (count_q != '0);
	assign res.data  = slot_q[rd_ptr_q];
	assign space_ok  = (count_q <= (PW+1)'(fnbd_pkg::RES_DEPTH - NP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PW-1:0];
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + n_push - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NP; k++) begin
			if (push.valid[k]) begin
				slot_q[wr_idx[k]] <= push.item[k];
			end
		end
	end

endmodule

// ===== design/four_neighbor_boundary_detect_core.sv =====
`timescale 1ns / 1ps
// top level of the four-neighbor inner boundary detector
// depends on fnbd_pkg, fnbd_stream_if and fnbd_res_queue

// Binary image in, one pixel per word in raster order; out comes one word per pixel telling
// whether it is foreground with a background four-neighbor (neighbors off the image count as
// foreground). Rate: one pixel per clock while the rows stream and the output is ready. A
// pixel's result is known when the pixel below it arrives, so row r is reported while row
// r+1 streams, and the pixel that completes it pushes the word into a four-deep result queue
// that the output port drains one word per clock while it is ready. During the last row each
// pixel from column 1 on also reports the pixel to its left, two words per pixel (one at
// column 0, three at the last pixel), so there the single output port sets the pace and input waits.
// The two previous rows live in one line memory, two bits wide and MAX_WIDTH deep, with one
// write and at most one prefetch read per pixel; it needs no clearing after reset.
// Registers: index 0 image width (clamped to 2..MAX_WIDTH), index 1 image height (at least 2);
// write them only between frames or while nothing is in flight.

module four_neighbor_boundary_detect_core #(
	parameter int MAX_WIDTH = fnbd_pkg::MAX_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fnbd_stream_if.sink   pix,
	fnbd_stream_if.source res,
	fnbd_stream_if.sink   cfg
);

	// column counter and line memory address width
	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	// width of the column compare, holds both the register and MAX_WIDTH
	localparam int EW = ($clog2(MAX_WIDTH + 1) > fnbd_pkg::IMG_W_BITS) ?
		$clog2(MAX_WIDTH + 1) : fnbd_pkg::IMG_W_BITS;
	localparam int RW = fnbd_pkg::ROW_W;
	localparam int OC = fnbd_pkg::OUT_COL_W;

	// one line memory entry: the row above and the row above that
	typedef struct packed {
		logic older;
		logic prev;
	} line_t;

	// configuration
	logic [fnbd_pkg::IMG_W_BITS-1:0] width_q;
	logic [RW-1:0]                   height_q;
	logic [EW-1:0]                   wlast;
	logic [RW-1:0]                   hlast;

	// position and window
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          left_q;     // row above, one column to the left
	logic          use_rd_q;   // next column comes from the memory read
	line_t         cur_q;      // memory entry of the current column
	line_t         nxt_q;      // entry of the next column after a row wrap
	line_t         first0_q;   // entries written at columns 0 and 1 of this row
	line_t         first1_q;
	logic          px_d1_q;    // this row, one and two columns back
	logic          px_d2_q;

	// line memory
	line_t         line_mem [MAX_WIDTH];
	line_t         rdata_q;
	logic [CW:0]   rd_sum;
	logic          rd_en;

	logic          accept;
	logic          space_ok;
	logic          px;
	logic          last_col;
	logic          last_row;
	logic          col_ge1;
	logic          col_ge2;
	logic          row_ge1;
	logic          row_ge2;
	line_t         nxt;
	line_t         wval;
	logic          up0;
	logic          rt0;
	logic          lf1;
	logic          lf2;
	fnbd_pkg::push_t push;

	// config port is always open
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fnbd_pkg::WIDTH_RESET;
			height_q <= fnbd_pkg::HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				fnbd_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg.data.value[fnbd_pkg::IMG_W_BITS-1:0];
				end
				fnbd_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg.data.value[RW-1:0];
				end
			endcase
		end
	end

	// last column and last row from the clamped sizes
	always_comb begin
		logic [EW-1:0] width_ext;
		width_ext = EW'(width_q);
		if (width_ext < EW'(2)) begin
			wlast = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			wlast = EW'(MAX_WIDTH - 1);
		end else begin
			wlast = width_ext - EW'(1);
		end
		if (height_q < RW'(2)) begin
			hlast = RW'(1);
		end else begin
			hlast = height_q - RW'(1);
		end
	end

	assign last_col = (EW'(col_q) >= wlast);
	assign last_row = (row_q >= hlast);
	assign col_ge1  = (col_q != '0);
	assign col_ge2  = (col_q > CW'(1));
	assign row_ge1  = (row_q != '0);
	assign row_ge2  = (row_q > RW'(1));

	assign pix.ready = space_ok;
	assign accept    = pix.valid & space_ok;
	assign px        = pix.data.pixel_in;

	// right-hand neighbor entry: fresh memory read in a row, held copy after a wrap
	assign nxt  = use_rd_q ? rdata_q : nxt_q;
	// write back: current row becomes the row above
	assign wval = '{older: cur_q.prev, prev: px};

	// prefetch two columns ahead, so it lands before that column becomes the right neighbor
	assign rd_sum = {1'b0, col_q} + (CW+1)'(2);
	assign rd_en  = accept && !last_col && (rd_sum < (CW+1)'(MAX_WIDTH));

	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[col_q] <= wval;
		end
		if (rd_en) begin
			rdata_q <= line_mem[rd_sum[CW-1:0]];
		end
	end

	// neighbor selection; off-image neighbors read as foreground
	assign up0 = row_ge2 ? cur_q.older : 1'b1;
	assign rt0 = last_col ? 1'b1 : nxt.prev;
	assign lf1 = col_ge2 ? px_d2_q : 1'b1;
	assign lf2 = col_ge1 ? px_d1_q : 1'b1;

	always_comb begin
		push = '0;
		// pixel above the current one, now that the pixel below it is here
		push.valid[0]          = accept && row_ge1;
		push.item[0].boundary  = cur_q.prev & ~(up0 & left_q & rt0 & px);
		push.item[0].out_row   = row_q - RW'(1);
		push.item[0].out_col   = OC'(col_q);
		push.item[0].frame_end = 1'b0;
		// last row: the pixel to the left, its right neighbor just arrived
		push.valid[1]          = accept && last_row && col_ge1;
		push.item[1].boundary  = px_d1_q & ~(left_q & lf1 & px);
		push.item[1].out_row   = row_q;
		push.item[1].out_col   = OC'(col_q - CW'(1));
		push.item[1].frame_end = 1'b0;
		// last pixel of the frame reports itself
		push.valid[2]          = accept && last_row && last_col;
		push.item[2].boundary  = px & ~(cur_q.prev & lf2);
		push.item[2].out_row   = row_q;
		push.item[2].out_col   = OC'(col_q);
		push.item[2].frame_end = 1'b1;
	end

	// position and window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= 1'b1;
			use_rd_q <= 1'b0;
		end else if (accept) begin
			if (last_col) begin
				col_q    <= '0;
				row_q    <= last_row ? '0 : row_q + RW'(1);
				left_q   <= 1'b1;
				use_rd_q <= 1'b0;
			end else begin
				col_q    <= col_q + CW'(1);
				left_q   <= cur_q.prev;
				use_rd_q <= 1'b1;
			end
		end
	end

	// window data; at a row wrap columns 0 and 1 come from the copies of this row's writes
	always_ff @(posedge clk) begin
		if (accept) begin
			px_d1_q <= px;
			px_d2_q <= px_d1_q;
			if (!col_ge1) begin
				first0_q <= wval;
			end
			if (col_q == CW'(1)) begin
				first1_q <= wval;
			end
			if (last_col) begin
				cur_q <= col_ge1 ? first0_q : wval;
				nxt_q <= (col_q == CW'(1)) ? wval : first1_q;
			end else begin
				cur_q <= nxt;
			end
		end
	end

	fnbd_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.res      (res)
	);

endmodule

// ===== design/fnbd_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the boundary detector, bound to the top level
// depends on fnbd_pkg and four_neighbor_boundary_detect_core

module fnbd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input fnbd_pkg::result_t out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// nothing comes out while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

	// input only backs up when results are waiting
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// two frame ends never leave in consecutive cycles
	a_frame_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.frame_end
		|=> !(out_valid && out_ready && out_data.frame_end))
		else $error("back-to-back frame end");

endmodule

bind four_neighbor_boundary_detect_core fnbd_checker u_fnbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.data)
);
